@@ design/vbc_pkg.sv @@
// shared types, constants and group helper for the variable-byte codec
// no dependencies; imported by every module of the block
package vbc_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int GROUP_COUNT = 5;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_COUNT - 1);

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] word_in;
        logic [BYTE_W-1:0] byte_in;
    } in_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_out;
        logic [WORD_W-1:0] word_out;
        logic              last;
    } out_t;

    // one unit of work for the back end: a word to serialize or a decoded word
    typedef struct packed {
        logic              is_word;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  top_idx;
    } job_t;

    function automatic logic [GROUP_W-1:0] group_of(
        input logic [WORD_W-1:0] w,
        input logic [IDX_W-1:0]  idx
    );
        logic [GROUP_W-1:0] g;
        unique case (idx)
            3'd0:    g = w[6:0];
            3'd1:    g = w[13:7];
            3'd2:    g = w[20:14];
            3'd3:    g = w[27:21];
            3'd4:    g = {3'b000, w[31:28]};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ design/vbc_front.sv @@
// front end: takes input beats, finds the leading group of a word to encode,
// collects decode bytes; depends on vbc_pkg
module vbc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  vbc_pkg::in_t  in_data,
    output logic          push,
    output vbc_pkg::job_t push_job
);
    import vbc_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_shift;
    logic              dec_done;
    logic [IDX_W-1:0]  top_idx;

    // highest nonzero group, lowest group always sent
    always_comb
    begin
        if (in_data.word_in[31:28] != '0)
            top_idx = 3'd4;
        else if (in_data.word_in[27:21] != '0)
            top_idx = 3'd3;
        else if (in_data.word_in[20:14] != '0)
            top_idx = 3'd2;
        else if (in_data.word_in[13:7] != '0)
            top_idx = 3'd1;
        else
            top_idx = 3'd0;
    end

    assign acc_shift = {acc_reg[WORD_W-GROUP_W-1:0], in_data.byte_in[BYTE_W-1:1]};
    // fifth byte closes the word whatever its flag
    assign dec_done  = !in_data.byte_in[0] || (cnt_reg == LAST_IDX);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        push_job.is_word = 1'b0;
        push_job.word    = in_data.word_in;
        push_job.top_idx = top_idx;
        if (in_fire)
        begin
            if (in_data.op == OP_ENCODE)
            begin
                push = 1'b1;
            end
            else if (dec_done)
            begin
                push             = 1'b1;
                push_job.is_word = 1'b1;
                push_job.word    = acc_shift;
                push_job.top_idx = '0;
                acc_next         = '0;
                cnt_next         = '0;
            end
            else
            begin
                acc_next = acc_shift;
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/vbc_queue.sv @@
// short job queue between front and back end
// depends on vbc_pkg for the job type
module vbc_queue #(
    parameter int Depth = vbc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vbc_pkg::job_t push_job,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop,
    output vbc_pkg::job_t pop_job
);
    import vbc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntMax = CntW'(Depth);

    job_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == CntMax);
    assign pop_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrMax) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrMax) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CntW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ design/vbc_back.sv @@
// back end: serializes encode jobs into bytes, passes decoded words,
// drives the output register; depends on vbc_pkg
module vbc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_avail,
    input  vbc_pkg::job_t job_in,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output vbc_pkg::out_t out_data
);
    import vbc_pkg::*;

    logic             job_valid_reg, job_valid_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;
    logic             out_free, emit, done;
    logic [GROUP_W-1:0] grp;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = job_valid_reg && out_free;
    assign done     = emit && (job_reg.is_word || (idx_reg == '0));
    assign pop      = job_avail && (!job_valid_reg || done);
    assign grp      = group_of(job_reg.word, idx_reg);

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            job_valid_next = 1'b1;
            job_next       = job_in;
            idx_next       = job_in.top_idx;
        end
        else if (done)
            job_valid_next = 1'b0;
        else if (emit)
            idx_next = idx_reg - 3'd1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_reg.is_word)
            begin
                out_next.kind     = KIND_WORD;
                out_next.byte_out = '0;
                out_next.word_out = job_reg.word;
                out_next.last     = 1'b1;
            end
            else
            begin
                out_next.kind     = KIND_BYTE;
                out_next.byte_out = {grp, idx_reg != '0};
                out_next.word_out = '0;
                out_next.last     = (idx_reg == '0);
            end
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/variable_byte_codec_top.sv @@
// top level of the variable-byte codec: front end, job queue, back end
// depends on vbc_pkg, vbc_front, vbc_queue, vbc_back
//
// Each input beat either encodes a 32-bit word (op 0) or feeds one coded
// byte to the decoder (op 1). An encode yields one to five byte beats, most
// significant 7-bit group first, continuation flag in bit 0. A decode byte
// yields a word beat when its flag is clear or it is the fifth byte of the
// word, otherwise nothing. Input is taken one beat per cycle while the job
// queue (QueueDepth entries) has room; the back end sends one output beat per
// cycle while the output is not stalled, one per byte for an encode and a
// single word beat for a decoded word. With nothing waiting ahead of it, an
// item passes through the job queue, the back end's job register and the
// output register before its first output beat is presented. Results come
// out in input order; encodes do not disturb a partly collected decode word.
module variable_byte_codec_top #(
    parameter int QueueDepth = vbc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  vbc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output vbc_pkg::out_t out_data
);
    import vbc_pkg::*;

    logic in_fire;
    logic push, full, pop, pop_valid;
    job_t push_job, pop_job;

    assign in_stall = full;
    assign in_fire  = in_valid && !full;

    vbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job)
    );

    vbc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_job   (pop_job)
    );

    vbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (pop_valid),
        .job_in    (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // a push never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    // decoded word beats are always final and carry no byte
    a_word_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_WORD)
            |-> (out_data.last && out_data.byte_out == '0))
        else $error("malformed word beat");

    // continuation flag and last mark agree on byte beats
    a_byte_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_BYTE)
            |-> (out_data.byte_out[0] != out_data.last))
        else $error("continuation flag disagrees with last");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for variable_byte_codec_top: encodes and decodes under random stalls
// depends on vbc_pkg and the codec RTL; builds its own prediction of every output beat
module testbench;

    import vbc_pkg::*;

    localparam int ItemTarget = 420;
    localparam int IdleLimit  = 2000;
    localparam int TailCycles = 20;

    typedef struct {
        in_t beat;
        int  gap;
        bit  drain_first;
    } codec_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    codec_item_t       codec_items[$];
    out_t              predicted_beats[$];
    logic [WORD_W-1:0] dec_acc;
    logic [2:0]        dec_count;

    int total_items;
    int items_taken;
    int results_seen;
    int fail_count;
    int idle_cycles;
    bit in_taken;
    bit quiet_sender;

    variable_byte_codec_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // --- prediction ---

    function automatic out_t byte_result(logic [GROUP_W-1:0] g, logic more, logic fin);
        out_t r;
        r.kind     = KIND_BYTE;
        r.byte_out = {g, more};
        r.word_out = '0;
        r.last     = fin;
        return r;
    endfunction

    task automatic predict_codec(in_t beat);
        logic [GROUP_W-1:0] groups[GROUP_COUNT];
        logic [WORD_W-1:0]  w;
        logic [WORD_W-1:0]  acc;
        logic [3:0]         cnt;
        bit                 started;
        out_t               r;
        if (beat.op == OP_ENCODE)
        begin
            w = beat.word_in;
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                groups[i] = w[GROUP_W-1:0];
                w = w >> GROUP_W;
            end
            started = 1'b0;
            for (int i = GROUP_COUNT - 1; i > 0; i--)
            begin
                if (groups[i] != '0 || started)
                begin
                    started = 1'b1;
                    predicted_beats.push_back(byte_result(groups[i], 1'b1, 1'b0));
                end
            end
            predicted_beats.push_back(byte_result(groups[0], 1'b0, 1'b1));
        end
        else
        begin
            acc = {dec_acc[WORD_W-GROUP_W-1:0], beat.byte_in[7:1]};
            cnt = {1'b0, dec_count} + 4'd1;
            if (!beat.byte_in[0] || cnt >= GROUP_COUNT)
            begin
                r.kind     = KIND_WORD;
                r.byte_out = '0;
                r.word_out = acc;
                r.last     = 1'b1;
                predicted_beats.push_back(r);
                dec_acc   = '0;
                dec_count = '0;
            end
            else
            begin
                dec_acc   = acc;
                dec_count = cnt[2:0];
            end
        end
    endtask

    // --- stimulus ---

    function automatic int pick_gap();
        int r;
        if (quiet_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic void queue_beat(logic op, logic [WORD_W-1:0] w, logic [BYTE_W-1:0] b,
                                       bit drain = 1'b0);
        codec_item_t it;
        it.beat.op      = op;
        it.beat.word_in = w;
        it.beat.byte_in = b;
        it.gap          = pick_gap();
        it.drain_first  = drain;
        codec_items.push_back(it);
    endfunction

    function automatic void queue_encode(logic [WORD_W-1:0] w, bit drain = 1'b0);
        queue_beat(OP_ENCODE, w, BYTE_W'($urandom_range(0, 255)), drain);
    endfunction

    function automatic void queue_decode(logic [BYTE_W-1:0] b);
        queue_beat(OP_DECODE, $urandom(), b);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return $urandom() >> $urandom_range(0, 31);
    endfunction

    // a coded word of one to five bytes, now and then split by an encode
    function automatic void queue_coded_word();
        int                n;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(1, GROUP_COUNT);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_encode(random_word());
            b[7:1] = GROUP_W'($urandom_range(0, 127));
            if (k < n - 1)
                b[0] = 1'b1;
            else if (n == GROUP_COUNT)
                b[0] = 1'($urandom_range(0, 1));
            else
                b[0] = 1'b0;
            queue_decode(b);
        end
    endfunction

    function automatic void build_stimulus();
        int pick;
        int drain_count;
        quiet_sender = 1'b0;
        drain_count  = 0;
        // encode extremes and every byte-count boundary
        queue_encode(32'h0000_0000);
        queue_encode(32'hFFFF_FFFF);
        queue_encode(32'h0000_007F);
        queue_encode(32'h0000_0080);
        queue_encode(32'h0000_3FFF);
        queue_encode(32'h0000_4000);
        queue_encode(32'h001F_FFFF);
        queue_encode(32'h0020_0000);
        queue_encode(32'h0FFF_FFFF);
        queue_encode(32'h1000_0000);
        // single-byte words
        queue_decode(8'h00);
        queue_decode(8'hFE);
        // five bytes all flagged: fifth ends the word, top bits fall off
        repeat (GROUP_COUNT) queue_decode(8'hFF);
        // partial word survives an encode in the middle
        queue_decode(8'h03);
        queue_encode(32'h1234_5678);
        queue_decode(8'h04);
        // five bytes, last one clear
        repeat (GROUP_COUNT - 1) queue_decode(8'hAB);
        queue_decode(8'h54);

        while (codec_items.size() < ItemTarget)
        begin
            if (codec_items.size() % 40 == 0)
                quiet_sender = ($urandom_range(0, 3) == 0);
            // sender waits for the block to empty before each of these
            if (codec_items.size() >= 200 && drain_count < 5)
            begin
                drain_count++;
                queue_encode(random_word(), 1'b1);
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_encode(pick < 10 ? $urandom() : random_word());
            else if (pick < 90)
                queue_coded_word();
            else
                queue_decode(BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    // --- sender ---

    always @(negedge clk)
    begin : sender
        logic        v;
        in_t         d;
        codec_item_t cur;
        bit          have_next;
        int          gap_left;
        v = in_valid;
        d = in_data;
        if (!rst_n)
            v = 1'b0;
        else if (!in_valid || in_taken)
        begin
            v = 1'b0;
            if (!have_next && codec_items.size() > 0)
            begin
                cur       = codec_items.pop_front();
                have_next = 1'b1;
                gap_left  = cur.gap;
            end
            if (have_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!(cur.drain_first && predicted_beats.size() > 0))
                begin
                    v         = 1'b1;
                    d         = cur.beat;
                    have_next = 1'b0;
                end
            end
        end
        in_valid <= v;
        in_data  <= d;
    end

    // --- receiver ---

    always @(negedge clk)
    begin : receiver
        logic s;
        int   pick;
        int   stall_left;
        int   calm_left;
        bit   held_long;
        s = 1'b0;
        if (rst_n)
        begin
            // one long hold so the job queue fills and the input stalls
            if (!held_long && results_seen >= 150)
            begin
                held_long  = 1'b1;
                stall_left = 60;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                s = 1'b1;
            end
            else if (calm_left > 0)
                calm_left--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    calm_left = $urandom_range(10, 40);
                else if (pick < 9)
                    stall_left = $urandom_range(8, 25);
                else if (pick < 35)
                    s = 1'b1;
            end
        end
        out_stall <= s;
    end

    // --- monitor ---

    always @(posedge clk)
    begin : monitor
        out_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                items_taken++;
                predict_codec(in_data);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (predicted_beats.size() == 0)
                begin
                    $error("output beat with nothing predicted: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = predicted_beats.pop_front();
                    if (out_data.kind !== want.kind)
                    begin
                        $error("kind: expected %0h, actual %0h", want.kind, out_data.kind);
                        fail_count++;
                    end
                    if (out_data.byte_out !== want.byte_out)
                    begin
                        $error("byte_out: expected %0h, actual %0h",
                               want.byte_out, out_data.byte_out);
                        fail_count++;
                    end
                    if (out_data.word_out !== want.word_out)
                    begin
                        $error("word_out: expected %0h, actual %0h",
                               want.word_out, out_data.word_out);
                        fail_count++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0h, actual %0h", want.last, out_data.last);
                        fail_count++;
                    end
                end
            end
            if (in_taken || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        dec_acc   = '0;
        dec_count = '0;
        build_stimulus();
        total_items = codec_items.size();
        repeat (5) @(posedge clk);
        #1 rst_n = 1'b1;
        while (items_taken < total_items || predicted_beats.size() != 0)
            @(negedge clk);
        repeat (TailCycles) @(negedge clk);
        if (fail_count == 0 && predicted_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
